/* design/ehp_pkg.sv */
package ehp_pkg;

  // One received byte of a frame.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_beat_t;

  // One header result per frame.
  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
    logic        is_vlan;
    logic [11:0] vlan_id;
    logic [15:0] ether_type;
    logic [4:0]  payload_offset;
  } out_beat_t;

  // Status codes
  localparam logic [2:0] StAccepted  = 3'd0;
  localparam logic [2:0] StNotOurs   = 3'd1;
  localparam logic [2:0] StBadType   = 3'd2;
  localparam logic [2:0] StNotSnap   = 3'd3;
  localparam logic [2:0] StTruncated = 3'd4;

  localparam logic [47:0] BcastMac   = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] Tpid8021q  = 16'h8100;
  localparam logic [11:0] VidMask    = 12'hFFF;
  localparam logic [15:0] MaxLength  = 16'd1500;
  localparam logic [15:0] MinType    = 16'd1536;
  localparam logic [7:0]  SnapDsap   = 8'hAA;
  localparam logic [4:0]  PlainHdr   = 5'd14;
  localparam logic [4:0]  TaggedHdr  = 5'd18;
  localparam logic [4:0]  LlcSnapLen = 5'd8;
  localparam logic [4:0]  IndexMax   = 5'd31;

endpackage

/* design/ethernet_header_parser.sv */
// The header result is registered into the output register, or into the skid register while the output is held.
// Throughput: one byte per cycle while in_stall_o is low, back to back across frames.
// Output side has a result register plus a one-entry skid register, so bytes keep
// flowing while a result waits; input stalls only when both are occupied.
// Reset (rst_ni low, async): clears own MAC, per-frame capture state and both valid flags.
module ethernet_header_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  // own MAC configuration
  input  logic              own_mac_we_i,
  input  logic [47:0]       own_mac_i,
  // byte stream in
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ehp_pkg::in_beat_t in_beat_i,
  // header result out
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ehp_pkg::out_beat_t out_beat_o
);

  logic [47:0] own_mac_q;

  // Per-frame capture state
  logic [4:0]  byte_index_q, byte_index_d;
  logic [47:0] dest_shift_q, dest_shift_d;
  logic [47:0] src_shift_q, src_shift_d;
  logic [15:0] first_type_q, first_type_d;
  logic [15:0] tag_control_q, tag_control_d;
  logic [15:0] inner_type_q, inner_type_d;
  logic [7:0]  dsap_q, dsap_d;
  logic [15:0] snap_type_q, snap_type_d;

  // Output register and skid register
  logic               out_valid_q;
  ehp_pkg::out_beat_t out_beat_q;
  logic               skid_valid_q;
  ehp_pkg::out_beat_t skid_beat_q;

  logic in_accept;
  logic push;
  logic out_pop;
  logic tagged_now;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign push       = in_accept && in_beat_i.frame_end;
  assign out_pop    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // Tag decision for the capture placement uses the type word seen so far.
  assign tagged_now = (first_type_q == ehp_pkg::Tpid8021q);

  // ---------------------------------------------------------------------------
  // Byte capture: place the incoming byte by its index within the frame.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [7:0] b;
    b             = in_beat_i.data_byte;
    dest_shift_d  = dest_shift_q;
    src_shift_d   = src_shift_q;
    first_type_d  = first_type_q;
    tag_control_d = tag_control_q;
    inner_type_d  = inner_type_q;
    dsap_d        = dsap_q;
    snap_type_d   = snap_type_q;

    if (byte_index_q < 5'd6) begin
      dest_shift_d = {dest_shift_q[39:0], b};
    end else if (byte_index_q < 5'd12) begin
      src_shift_d = {src_shift_q[39:0], b};
    end else if (byte_index_q < 5'd14) begin
      first_type_d = {first_type_q[7:0], b};
    end else if (byte_index_q < 5'd16) begin
      tag_control_d = {tag_control_q[7:0], b};
      // untagged: byte 14 is the LLC DSAP
      if (byte_index_q == 5'd14 && !tagged_now) begin
        dsap_d = b;
      end
    end else if (byte_index_q < 5'd18) begin
      inner_type_d = {inner_type_q[7:0], b};
    end else if (byte_index_q == 5'd18) begin
      if (tagged_now) begin
        dsap_d = b;
      end
    end else if (byte_index_q == 5'd20 || byte_index_q == 5'd21) begin
      if (!tagged_now) begin
        snap_type_d = {snap_type_q[7:0], b};
      end
    end else if (byte_index_q == 5'd24 || byte_index_q == 5'd25) begin
      if (tagged_now) begin
        snap_type_d = {snap_type_q[7:0], b};
      end
    end

    // saturate so long payloads don't wrap
    byte_index_d = (byte_index_q == ehp_pkg::IndexMax) ? byte_index_q
                                                       : byte_index_q + 5'd1;
  end

  // ---------------------------------------------------------------------------
  // Header decision on the frame's last byte, from the just-updated capture.
  // ---------------------------------------------------------------------------
  ehp_pkg::out_beat_t res;

  always_comb begin
    logic [5:0]  n;
    logic        is_tagged;
    logic [4:0]  hdr;
    logic [15:0] ftype;
    logic [2:0]  st;
    logic [15:0] etype;
    logic [4:0]  off;

    n         = {1'b0, byte_index_q} + 6'd1;   // bytes in frame so far, incl. this one
    is_tagged = (first_type_d == ehp_pkg::Tpid8021q);
    hdr       = is_tagged ? ehp_pkg::TaggedHdr : ehp_pkg::PlainHdr;
    ftype     = is_tagged ? inner_type_d : first_type_d;
    st        = ehp_pkg::StAccepted;
    etype     = 16'd0;
    off       = 5'd0;

    if (n < 6'd6) begin
      st = ehp_pkg::StTruncated;
    end else if (dest_shift_d != ehp_pkg::BcastMac && dest_shift_d != own_mac_q) begin
      st = ehp_pkg::StNotOurs;
    end else if (n < {1'b0, ehp_pkg::PlainHdr}) begin
      st = ehp_pkg::StTruncated;
    end else if (n < {1'b0, hdr}) begin
      st = ehp_pkg::StTruncated;
    end else if (ftype > ehp_pkg::MaxLength && ftype < ehp_pkg::MinType) begin
      st = ehp_pkg::StBadType;
    end else if (ftype <= ehp_pkg::MaxLength) begin
      // length form: LLC must carry a SNAP header
      if (n < {1'b0, hdr} + 6'd1) begin
        st = ehp_pkg::StTruncated;
      end else if (dsap_d != ehp_pkg::SnapDsap) begin
        st = ehp_pkg::StNotSnap;
      end else if (n < {1'b0, hdr} + {1'b0, ehp_pkg::LlcSnapLen}) begin
        st = ehp_pkg::StTruncated;
      end else begin
        etype = snap_type_d;
        off   = hdr + ehp_pkg::LlcSnapLen;
      end
    end else begin
      etype = ftype;
      off   = hdr;
    end

    res.status         = st;
    res.dest_mac       = dest_shift_d;
    res.src_mac        = src_shift_d;
    res.is_vlan        = (st == ehp_pkg::StAccepted) && is_tagged;
    res.vlan_id        = (st == ehp_pkg::StAccepted && is_tagged)
                         ? (tag_control_d[11:0] & ehp_pkg::VidMask) : 12'd0;
    res.ether_type     = etype;
    res.payload_offset = off;
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q     <= '0;
      byte_index_q  <= '0;
      dest_shift_q  <= '0;
      src_shift_q   <= '0;
      first_type_q  <= '0;
      tag_control_q <= '0;
      inner_type_q  <= '0;
      dsap_q        <= '0;
      snap_type_q   <= '0;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      if (own_mac_we_i) begin
        own_mac_q <= own_mac_i;
      end

      // capture state; cleared after the last byte of each frame
      if (in_accept) begin
        if (in_beat_i.frame_end) begin
          byte_index_q  <= '0;
          dest_shift_q  <= '0;
          src_shift_q   <= '0;
          first_type_q  <= '0;
          tag_control_q <= '0;
          inner_type_q  <= '0;
          dsap_q        <= '0;
          snap_type_q   <= '0;
        end else begin
          byte_index_q  <= byte_index_d;
          dest_shift_q  <= dest_shift_d;
          src_shift_q   <= src_shift_d;
          first_type_q  <= first_type_d;
          tag_control_q <= tag_control_d;
          inner_type_q  <= inner_type_d;
          dsap_q        <= dsap_d;
          snap_type_q   <= snap_type_d;
        end
      end

      // output register refills from skid first, else from a fresh result;
      // a push is impossible while skid is full (input is stalled)
      if (!out_valid_q || out_pop) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push;
        end
      end else if (push) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_pop) begin
      if (skid_valid_q) begin
        out_beat_q <= skid_beat_q;
      end else if (push) begin
        out_beat_q <= res;
      end
    end else if (push) begin
      skid_beat_q <= res;
    end
  end

`ifndef SYNTH
  // skid entry only exists behind an occupied output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while output register is empty");

  // after every frame end the output register holds a valid result
  a_push_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_valid_q)
    else $error("frame end did not yield a result");

  // accepted headers start the payload at one of the four legal offsets
  a_accept_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_beat_q.status == ehp_pkg::StAccepted) |->
      (out_beat_q.payload_offset == 5'd14 || out_beat_q.payload_offset == 5'd18 ||
       out_beat_q.payload_offset == 5'd22 || out_beat_q.payload_offset == 5'd26))
    else $error("accepted header with bad payload offset");

  // rejected frames carry no tag or type information
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_beat_q.status != ehp_pkg::StAccepted) |->
      (!out_beat_q.is_vlan && out_beat_q.vlan_id == 12'd0 &&
       out_beat_q.ether_type == 16'd0 && out_beat_q.payload_offset == 5'd0))
    else $error("rejected header carries decode fields");
`endif

endmodule
